// File: hdl/stlt_pkg.sv
// ----------------------------------------------------------------------------
// Stereo tremolo package
// Operation codes, register indexes, fixed widths and scale constants, and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package stlt_pkg;

  localparam int OpW        = 2;
  localparam int EntryIdxW  = 10;
  localparam int EntryValW  = 16;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 14;
  localparam int DepthW     = 11;
  localparam int SpeedW     = 14;
  localparam int OffsetW    = 10;
  localparam int FracW      = 16;

  typedef enum logic [OpW-1:0] {
    OP_SAMPLE  = 2'd0,
    OP_WRITE   = 2'd1,
    OP_RESTART = 2'd2
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEPTH  = 2'd0,
    REG_SPEED  = 2'd1,
    REG_OFFSET = 2'd2
  } reg_e;

  localparam logic [DepthW-1:0]  DepthReset  = 11'd1000;
  localparam logic [SpeedW-1:0]  SpeedReset  = 14'd1666;
  localparam logic [OffsetW-1:0] OffsetReset = 10'd540;

  localparam int unsigned DepthScale = 1000;
  localparam int unsigned SpeedScale = 10000;
  localparam int unsigned HalfTurn   = 360;
  localparam int unsigned Unity      = 32768;
  localparam int          UnityShift = 15;
  localparam int unsigned FracOne    = 65536;

  localparam int unsigned FullScale  = Unity * DepthScale;
  localparam int          GainW      = $clog2(FullScale + 1);
  localparam int          AttenW     = EntryValW + DepthW;

  localparam int unsigned StepScale  = FracOne * HalfTurn;
  localparam int          StepCycles = 1;
  localparam int          StepCntW   = $clog2(StepCycles + 1);

  typedef struct packed {
    logic sample_go;
    logic table_wr;
    logic restart;
    logic mul_en;
    logic gain_en;
    logic scale_en;
    logic out_load;
    logic step_en;
  } stlt_cmd_t;

  typedef struct packed {
    logic speed_wr;
    logic off_busy;
  } stlt_status_t;

endpackage

// File: hdl/stlt_in_if.sv
// ----------------------------------------------------------------------------
// Stereo tremolo input channel
// Valid/ready channel carrying one operation with its sample pair and table word.
// ----------------------------------------------------------------------------
interface stlt_in_if import stlt_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) ();

  logic                          valid;
  logic                          ready;
  logic [OpW-1:0]                operation;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;
  logic [EntryIdxW-1:0]          entry_index;
  logic [EntryValW-1:0]          entry_value;

  modport source (
    output valid, operation, left_in, right_in, entry_index, entry_value,
    input  ready
  );

  modport sink (
    input  valid, operation, left_in, right_in, entry_index, entry_value,
    output ready
  );

endinterface

// File: hdl/stlt_out_if.sv
// ----------------------------------------------------------------------------
// Stereo tremolo output channel
// Valid/ready channel carrying one modulated sample pair.
// ----------------------------------------------------------------------------
interface stlt_out_if #(
  parameter int SAMPLE_BITS = 16
) ();

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;

  modport source (
    output valid, left_out, right_out,
    input  ready
  );

  modport sink (
    input  valid, left_out, right_out,
    output ready
  );

endinterface

// File: hdl/stlt_ctrl.sv
// ----------------------------------------------------------------------------
// Stereo tremolo controller
// Sequences one sample pair through read, attenuate, gain and scale steps,
// owns the result valid flag and paces the phase step recompute.
// ----------------------------------------------------------------------------
module stlt_ctrl import stlt_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [OpW-1:0] in_op_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  stlt_status_t   status_i,
  output stlt_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_GAIN,
    S_SCALE,
    S_DONE
  } state_e;

  state_e               state_q;
  logic                 out_valid_q;
  logic [StepCntW-1:0]  step_cnt_q;
  logic                 accept;

  assign in_ready_o = (state_q == S_IDLE) && (step_cnt_q == '0) && !status_i.off_busy;
  assign accept     = in_valid_i && in_ready_o;

  assign cmd_o.sample_go = accept && (in_op_i == OP_SAMPLE);
  assign cmd_o.table_wr  = accept && (in_op_i == OP_WRITE);
  assign cmd_o.restart   = accept && (in_op_i == OP_RESTART);
  assign cmd_o.mul_en    = (state_q == S_READ);
  assign cmd_o.gain_en   = (state_q == S_GAIN);
  assign cmd_o.scale_en  = (state_q == S_SCALE);
  assign cmd_o.out_load  = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  assign cmd_o.step_en   = (step_cnt_q != '0);

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      step_cnt_q  <= '0;
    end else begin
      // recompute the phase step on every speed write
      if (status_i.speed_wr) begin
        step_cnt_q <= StepCntW'(StepCycles);
      end else if (step_cnt_q != '0) begin
        step_cnt_q <= step_cnt_q - 1'b1;
      end

      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (cmd_o.sample_go) begin
            state_q <= S_READ;
          end
        end
        S_READ:  state_q <= S_GAIN;
        S_GAIN:  state_q <= S_SCALE;
        S_SCALE: state_q <= S_DONE;
        S_DONE: begin
          // hold until the output register is free
          if (cmd_o.out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/stlt_datapath.sv
// ----------------------------------------------------------------------------
// Stereo tremolo datapath
// LFO table memory, phase accumulator, configuration registers, phase step
// reciprocal multiply, offset reduction and the two-lane gain pipeline.
// ----------------------------------------------------------------------------
module stlt_datapath import stlt_pkg::*; #(
  parameter int TABLE_ENTRIES = 720,
  parameter int SAMPLE_BITS   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  stlt_cmd_t                     cmd_i,
  output stlt_status_t                  status_o,
  input  logic                          cfg_we_i,
  input  logic [CfgIdxW-1:0]            cfg_index_i,
  input  logic [CfgDataW-1:0]           cfg_data_i,
  input  logic [SAMPLE_BITS-1:0]        left_in_i,
  input  logic [SAMPLE_BITS-1:0]        right_in_i,
  input  logic [EntryIdxW-1:0]          entry_index_i,
  input  logic [EntryValW-1:0]          entry_value_i,
  output logic signed [SAMPLE_BITS-1:0] left_out_o,
  output logic signed [SAMPLE_BITS-1:0] right_out_o
);

  localparam int IdxW        = $clog2(TABLE_ENTRIES);
  localparam int HalfEntries = TABLE_ENTRIES / 2;
  localparam int OffRedW     = $clog2((1 << OffsetW) + HalfEntries);
  localparam int OffReset    = (int'(OffsetReset) + HalfEntries) % TABLE_ENTRIES;

  localparam longint unsigned StepDen   = longint'(SpeedScale) * longint'(TABLE_ENTRIES);
  localparam longint unsigned SpeedMax  = longint'((1 << SpeedW) - 1);
  localparam int              StepK     = $clog2(SpeedMax * StepDen + 1);
  localparam int              RecipPad  = 8;
  localparam longint unsigned StepPre   = longint'(StepScale) << (StepK - RecipPad);
  localparam longint unsigned StepRecip =
    ((StepPre / StepDen) << RecipPad) +
    (((StepPre % StepDen) << RecipPad) + StepDen - 1) / StepDen;
  localparam int              RecipW    = $clog2(StepRecip + 1);
  localparam int              RecipLoW  = RecipW / 2;
  localparam int              RecipHiW  = RecipW - RecipLoW;
  localparam int              LoProdW   = SpeedW + RecipLoW;
  localparam int              HiProdW   = SpeedW + RecipHiW;
  localparam int              StepProdW = SpeedW + RecipW;
  localparam logic [RecipLoW-1:0] RecipLo = RecipLoW'(StepRecip);
  localparam logic [RecipHiW-1:0] RecipHi = RecipHiW'(StepRecip >> RecipLoW);
  localparam longint unsigned StepMax   = (SpeedMax * longint'(StepScale)) / StepDen;
  localparam int              StepW     = $clog2(StepMax + 1);
  localparam longint unsigned StepReset =
    (longint'(SpeedReset) * longint'(StepScale)) / StepDen;
  localparam int              SumW      = ((StepW > FracW) ? StepW : FracW) + 1;

  localparam int              ProdW     = SAMPLE_BITS + GainW;
  localparam int              XW        = ProdW - UnityShift;
  localparam int              RecipK    = XW + 10;
  localparam longint unsigned RecipM    =
    ((64'd1 << RecipK) + longint'(DepthScale) - 1) / longint'(DepthScale);
  localparam int              MW        = $clog2(RecipM + 1);
  localparam int              YW        = XW + MW;

  logic [EntryValW-1:0] lfo_mem [TABLE_ENTRIES];

  logic [DepthW-1:0]  depth_q;
  logic [OffRedW-1:0] off_q;
  logic [StepW-1:0]   step_q;
  logic [IdxW-1:0]    whole_q;
  logic [FracW-1:0]   frac_q;

  logic [LoProdW-1:0]   step_lo_q;
  logic [HiProdW-1:0]   step_hi_q;
  logic [StepProdW-1:0] step_prod;
  logic                 off_wrap;

  logic [SumW-1:0]  phase_sum;
  logic [IdxW:0]    whole_sum;
  logic [IdxW-1:0]  whole_d;
  logic [IdxW:0]    right_sum;
  logic [IdxW-1:0]  right_idx;

  logic [SAMPLE_BITS-1:0] smp_q  [2];
  logic [EntryValW-1:0]   val_q  [2];
  logic [AttenW-1:0]      att_q  [2];
  logic [SAMPLE_BITS-1:0] mag_q  [2];
  logic                   neg_q  [2];
  logic [ProdW-1:0]       prod_q [2];
  logic [YW-1:0]          y_q    [2];
  logic [SAMPLE_BITS-1:0] res_q  [2];

  logic [GainW-1:0]       gain   [2];
  logic [SAMPLE_BITS-1:0] quot   [2];

  assign step_prod = (StepProdW'(step_hi_q) << RecipLoW) + StepProdW'(step_lo_q);
  assign off_wrap  = {1'b0, off_q} >= (OffRedW+1)'(TABLE_ENTRIES);

  assign status_o.speed_wr = cfg_we_i && (cfg_index_i == REG_SPEED);
  assign status_o.off_busy = off_wrap;

  always_comb begin
    phase_sum = SumW'(frac_q) + SumW'(step_q);
    whole_sum = (IdxW+1)'(whole_q) + (IdxW+1)'(phase_sum[SumW-1:FracW]);
    if (whole_sum >= (IdxW+1)'(TABLE_ENTRIES)) begin
      whole_d = IdxW'(whole_sum - (IdxW+1)'(TABLE_ENTRIES));
    end else begin
      whole_d = IdxW'(whole_sum);
    end
    right_sum = (IdxW+1)'(whole_q) + (IdxW+1)'(off_q[IdxW-1:0]);
    if (right_sum >= (IdxW+1)'(TABLE_ENTRIES)) begin
      right_idx = IdxW'(right_sum - (IdxW+1)'(TABLE_ENTRIES));
    end else begin
      right_idx = IdxW'(right_sum);
    end
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      if (att_q[i] >= AttenW'(FullScale)) begin
        gain[i] = '0;
      end else begin
        gain[i] = GainW'(AttenW'(FullScale) - att_q[i]);
      end
      quot[i] = y_q[i][RecipK +: SAMPLE_BITS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= DepthReset;
      off_q   <= OffRedW'(OffReset);
      step_q  <= StepW'(StepReset);
      whole_q <= '0;
      frac_q  <= '0;
    end else begin
      if (cfg_we_i && (cfg_index_i == REG_DEPTH)) begin
        depth_q <= cfg_data_i[DepthW-1:0];
      end

      // reduce offset plus half turn modulo the table size
      if (cfg_we_i && (cfg_index_i == REG_OFFSET)) begin
        off_q <= OffRedW'(cfg_data_i[OffsetW-1:0]) + OffRedW'(HalfEntries);
      end else if (off_wrap) begin
        off_q <= off_q - OffRedW'(TABLE_ENTRIES);
      end

      if (cmd_i.step_en) begin
        step_q <= step_prod[StepK +: StepW];
      end

      if (cmd_i.restart) begin
        whole_q <= '0;
        frac_q  <= '0;
      end else if (cmd_i.sample_go) begin
        whole_q <= whole_d;
        frac_q  <= phase_sum[FracW-1:0];
      end
    end
  end

  // split the step reciprocal so each multiply stays narrow
  always_ff @(posedge clk_i) begin
    if (status_o.speed_wr) begin
      step_lo_q <= LoProdW'(cfg_data_i[SpeedW-1:0]) * LoProdW'(RecipLo);
      step_hi_q <= HiProdW'(cfg_data_i[SpeedW-1:0]) * HiProdW'(RecipHi);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.table_wr && (32'(entry_index_i) < TABLE_ENTRIES)) begin
      lfo_mem[IdxW'(entry_index_i)] <= entry_value_i;
    end
    if (cmd_i.sample_go) begin
      val_q[0] <= lfo_mem[whole_q];
      val_q[1] <= lfo_mem[right_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sample_go) begin
      smp_q[0] <= left_in_i;
      smp_q[1] <= right_in_i;
    end
    for (int i = 0; i < 2; i++) begin
      if (cmd_i.mul_en) begin
        att_q[i] <= AttenW'(val_q[i]) * AttenW'(depth_q);
        neg_q[i] <= smp_q[i][SAMPLE_BITS-1];
        mag_q[i] <= smp_q[i][SAMPLE_BITS-1] ? (~smp_q[i] + 1'b1) : smp_q[i];
      end
      if (cmd_i.gain_en) begin
        prod_q[i] <= ProdW'(mag_q[i]) * ProdW'(gain[i]);
      end
      if (cmd_i.scale_en) begin
        y_q[i] <= YW'(prod_q[i][ProdW-1:UnityShift]) * YW'(RecipM);
      end
      if (cmd_i.out_load) begin
        res_q[i] <= neg_q[i] ? (~quot[i] + 1'b1) : quot[i];
      end
    end
  end

  assign left_out_o  = res_q[0];
  assign right_out_o = res_q[1];

endmodule

// File: hdl/stereo_table_lfo_tremolo_unit.sv
// ----------------------------------------------------------------------------
// Stereo table LFO tremolo unit
// Attenuates stereo sample pairs by a loadable LFO table read at two phases.
// ----------------------------------------------------------------------------
// A sample pair is accepted with its table reads, then the controller walks it
// through attenuation multiply, sample multiply and reciprocal scaling and, in
// S_DONE, waits until the output register is free and loads the result there;
// the next pair is taken only after that load, never while a pair is in flight.
// Table writes and phase restarts give no result. The output register lets the
// next pair enter while a result waits. A write to lfo_speed recomputes the
// phase step by a split reciprocal multiply and holds off input while the new
// step is loaded after the write, and a write to stereo_offset folds offset
// plus half the table down by one table length at a time, with input held off
// meanwhile. The table has no reset: read only entries that have been written.
module stereo_table_lfo_tremolo_unit import stlt_pkg::*; #(
  parameter int TABLE_ENTRIES = 720,
  parameter int SAMPLE_BITS   = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  stlt_in_if.sink             in_i,
  stlt_out_if.source          out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  stlt_cmd_t    cmd;
  stlt_status_t status;

  stlt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_op_i     (in_i.operation),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  stlt_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .left_in_i     (in_i.left_in),
    .right_in_i    (in_i.right_in),
    .entry_index_i (in_i.entry_index),
    .entry_value_i (in_i.entry_value),
    .left_out_o    (out_o.left_out),
    .right_out_o   (out_o.right_out)
  );

endmodule

// File: hdl/stlt_checker.sv
// ----------------------------------------------------------------------------
// Stereo tremolo port checker
// Watches the top level ports for handshake and sequencing rules.
// ----------------------------------------------------------------------------
module stlt_checker import stlt_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_i,
  input logic [OpW-1:0]         in_op_i,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic [SAMPLE_BITS-1:0] left_out_i,
  input logic [SAMPLE_BITS-1:0] right_out_i,
  input logic                   cfg_we_i,
  input logic [CfgIdxW-1:0]     cfg_index_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(left_out_i) && $stable(right_out_i))
    else $error("result changed while stalled");

  a_speed_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_index_i == REG_SPEED) |=> !in_ready_i)
    else $error("input taken while phase step is recomputed");

  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_op_i == OP_SAMPLE) |=> !in_ready_i)
    else $error("input taken while a sample pair is in flight");

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !$rose(out_valid_i))
    else $error("result transaction appeared right after acceptance");

endmodule

bind stereo_table_lfo_tremolo_unit stlt_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_stlt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_op_i     (in_i.operation),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .left_out_i  (out_o.left_out),
  .right_out_i (out_o.right_out),
  .cfg_we_i    (cfg_we_i),
  .cfg_index_i (cfg_index_i)
);
